// File: rtl/lmd_pkg.sv
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared widths, register codes, item types and helpers of the peak detector.
// ----------------------------------------------------------------------------
package lmd_pkg;

    localparam int MAX_ROWS = 4096;
    localparam int MAX_COLS = 4096;
    localparam int PIX_W    = 16;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int SIZE_W   = 13;
    localparam int CNT_W    = 25;
    localparam int OUT_W    = 12;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 56;

    localparam logic [CNT_W-1:0]  COUNT_MAX       = '1;
    localparam logic [PIX_W-1:0]  THRESHOLD_RESET = PIX_W'(200);
    localparam logic [SIZE_W-1:0] ROWS_RESET      = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] COLS_RESET      = SIZE_W'(4096);
    localparam logic [CNT_W-1:0]  LIMIT_RESET     = CNT_W'(1677722);
    localparam logic [SIZE_W-1:0] SIZE_MIN        = SIZE_W'(3);

    typedef enum logic [1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_FRAME_ROWS = 2'd1,
        REG_FRAME_COLS = 2'd2,
        REG_PEAK_LIMIT = 2'd3
    } t_reg_idx;

    // one line store entry: the two previous columns at one row
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] recent;
    } t_line;

    // scan position of one pixel
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             new_frame;
        logic             interior;
    } t_pos;

    // one reported peak
    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] number;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
    } t_peak;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: rtl/local_max_detector_4conn.sv
// ----------------------------------------------------------------------------
// local_max_detector_4conn
// Streaming 4-connected local maximum detector over a column-major scan.
// ----------------------------------------------------------------------------
// Pixels arrive one per request on the slave stream in column-major order,
// frame_rows pixels per column. When pixel (r,c) arrives, pixel (r,c-1) is
// judged: it is a peak when it lies off every frame edge, is strictly above
// the threshold and strictly above its up, down, left and right neighbours.
// Each peak gives one request on the master stream with its 1-based row and
// column and the running peak number; tlast marks the peak that reaches
// peak_limit, after which the frame yields no more peaks. tuser on the input
// (or the end of the last column) starts a new frame and clears the count.
// The block takes one pixel per clock unless a peak waits on a full output;
// a peak goes through the judge stage and the output register after its right
// neighbour is taken. Throughput is set by the line store: one 4096 x 32 bit
// memory holding the two previous columns, read at rows r and r+1 on accept
// and written back at row r as the judge stage moves on, with forwarding of
// that write. Not cleared, it is only used at rows written in this frame.
// ----------------------------------------------------------------------------
module local_max_detector_4conn (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lmd_pkg::TDATA_IN_W-1:0]       s_axis_tdata,   // [15:0] pixel_value
    input  logic                                 s_axis_tuser,   // [0] frame_start
    // peak stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lmd_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,   // [11:0] peak_row,
                                                                 // [23:12] peak_col,
                                                                 // [48:24] peak_number
    output logic                                 m_axis_tlast,   // limit_reached
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lmd_pkg::ADDR_W-1:0]           paddr,
    input  logic [lmd_pkg::APB_W-1:0]            pwdata,
    output logic [lmd_pkg::APB_W-1:0]            prdata,
    output logic                                 pready
);

    // configuration registers
    logic [lmd_pkg::PIX_W-1:0]  r_threshold;
    logic [lmd_pkg::SIZE_W-1:0] r_frame_rows;
    logic [lmd_pkg::SIZE_W-1:0] r_frame_cols;
    logic [lmd_pkg::CNT_W-1:0]  r_peak_limit;
    lmd_pkg::t_reg_idx          reg_idx;
    logic                       cfg_wr;

    // input side
    logic                       in_accept;
    lmd_pkg::t_pos              pos;

    // judge stage
    logic                       r_s1_valid;
    lmd_pkg::t_pos              r_s1_pos;
    logic [lmd_pkg::PIX_W-1:0]  r_s1_pix;
    logic                       s1_adv;
    logic                       hit;
    lmd_pkg::t_peak             peak;
    lmd_pkg::t_line             line_a;
    lmd_pkg::t_line             wb_line;
    logic [lmd_pkg::PIX_W-1:0]  down;

    // output register
    logic                       r_out_valid;
    lmd_pkg::t_peak             r_out_peak;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = lmd_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= lmd_pkg::THRESHOLD_RESET;
            r_frame_rows <= lmd_pkg::ROWS_RESET;
            r_frame_cols <= lmd_pkg::COLS_RESET;
            r_peak_limit <= lmd_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                lmd_pkg::REG_THRESHOLD:  r_threshold  <= pwdata[lmd_pkg::PIX_W-1:0];
                lmd_pkg::REG_FRAME_ROWS: r_frame_rows <= pwdata[lmd_pkg::SIZE_W-1:0];
                lmd_pkg::REG_FRAME_COLS: r_frame_cols <= pwdata[lmd_pkg::SIZE_W-1:0];
                lmd_pkg::REG_PEAK_LIMIT: r_peak_limit <= pwdata[lmd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lmd_pkg::REG_THRESHOLD:  prdata = lmd_pkg::APB_W'(r_threshold);
            lmd_pkg::REG_FRAME_ROWS: prdata = lmd_pkg::APB_W'(r_frame_rows);
            lmd_pkg::REG_FRAME_COLS: prdata = lmd_pkg::APB_W'(r_frame_cols);
            lmd_pkg::REG_PEAK_LIMIT: prdata = lmd_pkg::APB_W'(r_peak_limit);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // the judge stage moves on unless it holds a peak and the output is full
    assign s1_adv        = r_s1_valid && (!hit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- scan position ----------------
    lmd_scan_ctrl u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (s_axis_tuser),
        .i_frame_rows  (r_frame_rows),
        .i_frame_cols  (r_frame_cols),
        .o_pos         (pos)
    );

    // ---------------- line store ----------------
    // port a: this row (centre and left), port b: next row (down)
    // write back shifts recent into older and stores the new pixel
    always_comb begin
        wb_line.older  = line_a.recent;
        wb_line.recent = r_s1_pix;
    end

    lmd_line_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (pos.row),
        .i_rd_addr_b (pos.row + 1'b1),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_pos.row),
        .i_wr_data   (wb_line),
        .o_line_a    (line_a),
        .o_recent_b  (down)
    );

    // ---------------- judge stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos <= pos;
            r_s1_pix <= s_axis_tdata[lmd_pkg::PIX_W-1:0];
        end
    end

    lmd_peak_eval u_eval (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s1_valid),
        .i_advance    (s1_adv),
        .i_pos        (r_s1_pos),
        .i_right      (r_s1_pix),
        .i_line       (line_a),
        .i_down       (down),
        .i_threshold  (r_threshold),
        .i_peak_limit (r_peak_limit),
        .o_hit        (hit),
        .o_peak       (peak)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && hit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && hit) begin
            r_out_peak <= peak;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lmd_pkg::TDATA_OUT_W'({r_out_peak.number, r_out_peak.col,
                                                  r_out_peak.row});
    assign m_axis_tlast  = r_out_peak.last;

endmodule

// File: rtl/lmd_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lmd_scan_ctrl
// Row and column tracking of the column-major pixel scan.
// ----------------------------------------------------------------------------
module lmd_scan_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_frame_start,
    input  logic [lmd_pkg::SIZE_W-1:0]    i_frame_rows,
    input  logic [lmd_pkg::SIZE_W-1:0]    i_frame_cols,
    output lmd_pkg::t_pos                 o_pos
);

    logic [lmd_pkg::SIZE_W-1:0] r_row, n_row;
    logic [lmd_pkg::SIZE_W-1:0] r_col, n_col;
    logic [lmd_pkg::SIZE_W-1:0] rows, cols;
    logic [lmd_pkg::SIZE_W-1:0] row_cur, col_inc, col_cur;
    logic                       wrap_row, wrap_col;

    always_comb begin
        rows     = lmd_pkg::clamp_size(i_frame_rows, lmd_pkg::SIZE_W'(lmd_pkg::MAX_ROWS));
        cols     = lmd_pkg::clamp_size(i_frame_cols, lmd_pkg::SIZE_W'(lmd_pkg::MAX_COLS));
        wrap_row = (r_row >= rows);
        col_inc  = wrap_row ? r_col + 1'b1 : r_col;
        wrap_col = (col_inc >= cols);
        if (i_frame_start) begin
            row_cur = '0;
            col_cur = '0;
        end else begin
            row_cur = wrap_row ? '0 : r_row;
            col_cur = wrap_col ? '0 : col_inc;
        end
        n_row = row_cur + 1'b1;
        n_col = col_cur;

        o_pos.row       = row_cur[lmd_pkg::ROW_W-1:0];
        o_pos.col       = col_cur[lmd_pkg::COL_W-1:0];
        o_pos.new_frame = i_frame_start | wrap_col;
        // judged pixel sits one column back, away from every edge
        o_pos.interior  = (col_cur >= lmd_pkg::SIZE_W'(2)) && (row_cur != '0)
                          && ((row_cur + lmd_pkg::SIZE_W'(2)) <= rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// File: rtl/lmd_line_store.sv
// ----------------------------------------------------------------------------
// lmd_line_store
// Two-column line store with two read ports and write forwarding.
// ----------------------------------------------------------------------------
module lmd_line_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [lmd_pkg::ROW_W-1:0]     i_rd_addr_a,
    input  logic [lmd_pkg::ROW_W-1:0]     i_rd_addr_b,
    input  logic                          i_wr_en,
    input  logic [lmd_pkg::ROW_W-1:0]     i_wr_addr,
    input  lmd_pkg::t_line                i_wr_data,
    output lmd_pkg::t_line                o_line_a,
    output logic [lmd_pkg::PIX_W-1:0]     o_recent_b
);

    lmd_pkg::t_line mem [lmd_pkg::MAX_ROWS];
    lmd_pkg::t_line r_rd_a, r_rd_b, r_wr_data;
    logic           r_fwd_a, r_fwd_b;
    lmd_pkg::t_line line_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a    <= mem[i_rd_addr_a];
            r_rd_b    <= mem[i_rd_addr_b];
            r_wr_data <= i_wr_data;
        end
    end

    // a write landing on the same edge as the read wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_a <= i_wr_en && (i_wr_addr == i_rd_addr_a);
            r_fwd_b <= i_wr_en && (i_wr_addr == i_rd_addr_b);
        end
    end

    always_comb begin
        o_line_a   = r_fwd_a ? r_wr_data : r_rd_a;
        line_b     = r_fwd_b ? r_wr_data : r_rd_b;
        o_recent_b = line_b.recent;
    end

endmodule

// File: rtl/lmd_peak_eval.sv
// ----------------------------------------------------------------------------
// lmd_peak_eval
// Neighbour compare, peak counting and search stop for one judged pixel.
// ----------------------------------------------------------------------------
module lmd_peak_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_advance,
    input  lmd_pkg::t_pos                 i_pos,
    input  logic [lmd_pkg::PIX_W-1:0]     i_right,
    input  lmd_pkg::t_line                i_line,
    input  logic [lmd_pkg::PIX_W-1:0]     i_down,
    input  logic [lmd_pkg::PIX_W-1:0]     i_threshold,
    input  logic [lmd_pkg::CNT_W-1:0]     i_peak_limit,
    output logic                          o_hit,
    output lmd_pkg::t_peak                o_peak
);

    logic [lmd_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_stop, n_stop;
    logic [lmd_pkg::PIX_W-1:0] r_up;
    logic [lmd_pkg::CNT_W-1:0] base_count, inc_count;
    logic                      base_stop, is_max, lim;
    logic signed [lmd_pkg::PIX_W-1:0] centre;

    always_comb begin
        centre     = $signed(i_line.recent);
        base_count = i_pos.new_frame ? '0 : r_count;
        base_stop  = i_pos.new_frame ? 1'b0 : r_stop;
        // up neighbour is the centre of the previous pixel in this column
        is_max = (centre > $signed(i_threshold)) && (centre > $signed(i_line.older))
                 && (centre > $signed(r_up)) && (centre > $signed(i_down))
                 && (centre > $signed(i_right));
        o_hit     = i_valid && i_pos.interior && !base_stop && is_max;
        inc_count = (base_count != lmd_pkg::COUNT_MAX) ? base_count + 1'b1 : base_count;
        lim       = (inc_count == i_peak_limit);
        n_count   = o_hit ? inc_count : base_count;
        n_stop    = o_hit ? lim : base_stop;

        o_peak.row    = lmd_pkg::OUT_W'(i_pos.row) + 1'b1;
        o_peak.col    = lmd_pkg::OUT_W'(i_pos.col);
        o_peak.number = inc_count;
        o_peak.last   = lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_stop  <= 1'b0;
        end else if (i_advance) begin
            r_count <= n_count;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_up <= i_line.recent;
        end
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-connected local maximum detector.
// ----------------------------------------------------------------------------
// Column-major pixel frames go in on the slave stream and peak reports are
// checked on the master stream against an in-bench predictor. The predictor
// keeps its own two column stores, scan position, peak count and register
// copies. A short directed part covers the value extremes, wrap at the end of
// a frame, a frame restart in mid-frame, size clamping and a size change in
// mid-frame, the first part under a long receiver stall. Random phases follow
// with new register settings and random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 1060;
    localparam int DRAIN_CYCLES = 8;        // peak follows its right pixel through the judge stage and output register
    localparam int SETTLE_LIMIT = 1000000;

    typedef enum int {
        PX_FULL,                            // any 16 bit value
        PX_NEAR,                            // close to the threshold, many ties
        PX_EXTREME                          // end points of the range, the threshold, or any value
    } t_px_mode;

    typedef struct packed {
        logic                      fs;
        logic [lmd_pkg::PIX_W-1:0] px;
    } t_pixel_req;

    // dut ports
    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lmd_pkg::TDATA_IN_W-1:0]  s_axis_tdata  = '0;    // [15:0] pixel_value
    logic                            s_axis_tuser  = 1'b0;  // [0] frame_start
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lmd_pkg::TDATA_OUT_W-1:0] m_axis_tdata;          // [11:0] row, [23:12] col,
                                                            // [48:24] number
    logic                            m_axis_tlast;          // limit_reached
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [lmd_pkg::ADDR_W-1:0]      paddr         = '0;
    logic [lmd_pkg::APB_W-1:0]       pwdata        = '0;
    logic [lmd_pkg::APB_W-1:0]       prdata;
    logic                            pready;

    // stimulus and scoreboard
    t_pixel_req      pixel_q[$];            // pixels waiting to be offered
    lmd_pkg::t_peak  peaks_due[$];          // predicted peaks, oldest first
    bit              px_taken  = 1'b0;      // pixel request accepted at the last rising edge
    bit              tx_quiet  = 1'b0;      // no gaps on the pixel side
    bit              rx_quiet  = 1'b0;      // no gaps on the peak side
    int              tx_gap    = 0;
    int              rx_gap    = 0;
    int              rx_hold   = 0;         // long receiver stall, counted down by the receiver
    int              n_errors  = 0;

    // predictor state
    logic signed [lmd_pkg::PIX_W-1:0]  recent_px [lmd_pkg::MAX_ROWS];
    logic signed [lmd_pkg::PIX_W-1:0]  older_px  [lmd_pkg::MAX_ROWS];
    int                                row_pos   = 0;
    int                                col_pos   = 0;
    logic [lmd_pkg::CNT_W-1:0]         peak_cnt  = '0;
    bit                                stopped   = 1'b0;
    logic signed [lmd_pkg::PIX_W-1:0]  thr_cfg   = lmd_pkg::THRESHOLD_RESET;
    logic [lmd_pkg::SIZE_W-1:0]        rows_cfg  = lmd_pkg::ROWS_RESET;
    logic [lmd_pkg::SIZE_W-1:0]        cols_cfg  = lmd_pkg::COLS_RESET;
    logic [lmd_pkg::CNT_W-1:0]         limit_cfg = lmd_pkg::LIMIT_RESET;

    local_max_detector_4conn dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far above the slowest legal run (every gap and stall at its longest)
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // register size after clamping into 3..hi
    function automatic int clip_span(input logic [lmd_pkg::SIZE_W-1:0] v, input int hi);
        if (int'(v) < 3) return 3;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // random gap: none when quiet or most of the time, else from a short or a long range
    function automatic int pick_gap(input bit quiet);
        int r;
        r = int'($urandom_range(0, 99));
        if (quiet || r < 55) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // half the time, garbage above the register width
    function automatic logic [lmd_pkg::APB_W-1:0] with_junk(
        input logic [lmd_pkg::APB_W-1:0] v, input int width);
        logic [lmd_pkg::APB_W-1:0] mask;
        mask = (lmd_pkg::APB_W'(1) << width) - lmd_pkg::APB_W'(1);
        if ($urandom_range(0, 1)) return v;
        return (v & mask) | (lmd_pkg::APB_W'($urandom) & ~mask);
    endfunction

    // mostly small frames, sometimes below the minimum
    function automatic logic [lmd_pkg::SIZE_W-1:0] pick_span();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 6) return lmd_pkg::SIZE_W'($urandom_range(0, 2));
        if (r < 16) return lmd_pkg::SIZE_W'($urandom_range(13, 24));
        return lmd_pkg::SIZE_W'($urandom_range(3, 12));
    endfunction

    function automatic logic [lmd_pkg::PIX_W-1:0] gen_px(input t_px_mode mode);
        logic [lmd_pkg::PIX_W-1:0] v;
        int                        r;
        r = int'($urandom_range(0, 3));
        if (mode == PX_NEAR) begin
            v = thr_cfg + lmd_pkg::PIX_W'($urandom_range(0, 16)) - lmd_pkg::PIX_W'(8);
        end else if (mode == PX_EXTREME && r == 0) begin
            v = 16'h8000;
        end else if (mode == PX_EXTREME && r == 1) begin
            v = 16'h7fff;
        end else if (mode == PX_EXTREME && r == 2) begin
            v = thr_cfg;
        end else begin
            v = lmd_pkg::PIX_W'($urandom);
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // predictor: pixel (r,c) arrives, pixel (r,c-1) is judged
    // ------------------------------------------------------------------------
    task automatic detect_peak(input logic [lmd_pkg::PIX_W-1:0] px_bits, input logic fs);
        logic signed [lmd_pkg::PIX_W-1:0] px, c_val, w_val, n_val, s_val;
        int                               rows, cols, r;
        logic                             hit_limit;
        lmd_pkg::t_peak                   pk;
        px   = px_bits;
        rows = clip_span(rows_cfg, lmd_pkg::MAX_ROWS);
        cols = clip_span(cols_cfg, lmd_pkg::MAX_COLS);
        if (fs) begin
            row_pos  = 0;
            col_pos  = 0;
            peak_cnt = '0;
            stopped  = 1'b0;
        end else begin
            // wrap at the end of a column, then at the end of the frame
            if (row_pos >= rows) begin
                row_pos = 0;
                col_pos++;
            end
            if (col_pos >= cols) begin
                col_pos  = 0;
                peak_cnt = '0;
                stopped  = 1'b0;
            end
        end
        r = row_pos;
        if (!stopped && col_pos >= 2 && r >= 1 && r + 2 <= rows) begin
            // centre and its west, north and south neighbours; px is the east one
            c_val = recent_px[r];
            w_val = older_px[r];
            n_val = older_px[r-1];
            s_val = recent_px[r+1];
            if (c_val > thr_cfg && c_val > w_val && c_val > n_val &&
                c_val > s_val && c_val > px) begin
                if (peak_cnt < lmd_pkg::COUNT_MAX) peak_cnt++;
                hit_limit = (peak_cnt == limit_cfg);
                if (hit_limit) stopped = 1'b1;
                pk.row    = lmd_pkg::OUT_W'(r + 1);
                pk.col    = lmd_pkg::OUT_W'(col_pos);
                pk.number = peak_cnt;
                pk.last   = hit_limit;
                peaks_due.push_back(pk);
            end
        end
        older_px[r]  = recent_px[r];
        recent_px[r] = px;
        row_pos      = r + 1;
    endtask

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // apb write: setup cycle, access cycle, register taken at the access edge
    task automatic cfg_write(input lmd_pkg::t_reg_idx idx,
                             input logic [lmd_pkg::APB_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            lmd_pkg::REG_THRESHOLD:  thr_cfg   = val[lmd_pkg::PIX_W-1:0];
            lmd_pkg::REG_FRAME_ROWS: rows_cfg  = val[lmd_pkg::SIZE_W-1:0];
            lmd_pkg::REG_FRAME_COLS: cols_cfg  = val[lmd_pkg::SIZE_W-1:0];
            lmd_pkg::REG_PEAK_LIMIT: limit_cfg = val[lmd_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_px(input logic [lmd_pkg::PIX_W-1:0] v, input logic fs);
        t_pixel_req req;
        req.px = v;
        req.fs = fs;
        pixel_q.push_back(req);
    endtask

    // 3x3 frame with one centre value on a flat background
    task automatic push_cross(input logic [lmd_pkg::PIX_W-1:0] bg,
                              input logic [lmd_pkg::PIX_W-1:0] ctr, input logic fs);
        for (int k = 0; k < 9; k++) push_px((k == 4) ? ctr : bg, fs && (k == 0));
    endtask

    // wait until every pixel is taken and every peak is back, then let the pipe drain
    task automatic settle(input int max_cycles);
        int k;
        k = 0;
        while ((pixel_q.size() != 0 || s_axis_tvalid || peaks_due.size() != 0) &&
               k < max_cycles) begin
            @(posedge i_clk);
            k++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // whole frames of the current size, at most max_items pixels;
    // noisy frames may be cut short or restarted
    task automatic push_frames(input int n_frames, input t_px_mode mode, input int pause_at,
                               input bit noisy, input int max_items, output int pushed);
        int   len, full, k, f;
        bit   cut;
        logic fs;
        pushed = 0;
        cut    = 1'b0;
        for (f = 0; f < n_frames && pushed < max_items; f++) begin
            full = clip_span(rows_cfg, lmd_pkg::MAX_ROWS) *
                   clip_span(cols_cfg, lmd_pkg::MAX_COLS);
            len  = full;
            if (noisy && $urandom_range(0, 9) == 0) begin
                len = int'($urandom_range(1, len));
                cut = 1'b1;
            end
            for (k = 0; k < len && pushed < max_items; k++) begin
                // later frames start with the flag or by wrapping past the last pixel
                fs = (k == 0) && (f == 0 || cut || $urandom_range(0, 1));
                if (noisy && k > 0 && $urandom_range(0, 199) == 0) fs = 1'b1;
                push_px(gen_px(mode), fs);
                pushed++;
                // sender waits for every peak to come back, then resumes mid-frame
                if (pushed == pause_at) settle(SETTLE_LIMIT);
            end
            if (len == full) cut = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel driver: holds a request until taken, then an optional gap
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : pixel_driver
        t_pixel_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_axis_tvalid || px_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                nxt = pixel_q.pop_front();
                s_axis_tdata  <= nxt.px;
                s_axis_tuser  <= nxt.fs;
                s_axis_tvalid <= 1'b1;
                tx_gap = pick_gap(tx_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // peak receiver: random ready, plus long stalls on demand
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_gap = pick_gap(rx_quiet);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check peaks in order, predict from every accepted pixel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        lmd_pkg::t_peak want;
        if (!i_rst_n) begin
            px_taken = 1'b0;
        end else begin
            px_taken = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (peaks_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected peak row %0d col %0d number %0d",
                        m_axis_tdata[lmd_pkg::OUT_W-1:0],
                        m_axis_tdata[2*lmd_pkg::OUT_W-1:lmd_pkg::OUT_W],
                        m_axis_tdata[2*lmd_pkg::OUT_W+lmd_pkg::CNT_W-1:2*lmd_pkg::OUT_W]));
                end else begin
                    want = peaks_due.pop_front();
                    if (m_axis_tdata[lmd_pkg::OUT_W-1:0] !== want.row ||
                        m_axis_tdata[2*lmd_pkg::OUT_W-1:lmd_pkg::OUT_W] !== want.col ||
                        m_axis_tdata[2*lmd_pkg::OUT_W+lmd_pkg::CNT_W-1:2*lmd_pkg::OUT_W]
                            !== want.number ||
                        m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "peak got r%0d c%0d n%0d l%0b want r%0d c%0d n%0d l%0b",
                            m_axis_tdata[lmd_pkg::OUT_W-1:0],
                            m_axis_tdata[2*lmd_pkg::OUT_W-1:lmd_pkg::OUT_W],
                            m_axis_tdata[2*lmd_pkg::OUT_W+lmd_pkg::CNT_W-1:2*lmd_pkg::OUT_W],
                            m_axis_tlast, want.row, want.col, want.number, want.last));
                    end
                end
            end
            if (px_taken) detect_peak(s_axis_tdata[lmd_pkg::PIX_W-1:0], s_axis_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                        k, phase, n_random, pushed, pick, pause;
        logic [lmd_pkg::PIX_W-1:0] thr_val;
        logic [lmd_pkg::CNT_W-1:0] lim_val;
        t_px_mode                  mode;
        for (k = 0; k < lmd_pkg::MAX_ROWS; k++) begin
            recent_px[k] = '0;
            older_px[k]  = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lowest threshold, limit of one, smallest frame
        cfg_write(lmd_pkg::REG_THRESHOLD,  32'h0000_8000);
        cfg_write(lmd_pkg::REG_FRAME_ROWS, 32'd3);
        cfg_write(lmd_pkg::REG_FRAME_COLS, 32'd3);
        cfg_write(lmd_pkg::REG_PEAK_LIMIT, 32'd1);
        // receiver stalls while three peaks are on the way, so the block backs up
        rx_hold = 200;
        push_cross(16'h8000, 16'h7fff, 1'b1);
        // next frame by wrapping past the last pixel, no start flag
        push_cross(16'h8000, 16'h7fff, 1'b0);
        // frame restarted in mid-frame, centre just above the background
        push_px(16'h8000, 1'b0);
        push_px(16'h8000, 1'b0);
        push_cross(16'h8000, 16'h8001, 1'b1);
        settle(SETTLE_LIMIT);

        // highest threshold never passed, limit zero, sizes below the minimum
        cfg_write(lmd_pkg::REG_THRESHOLD,  32'h0000_7fff);
        cfg_write(lmd_pkg::REG_PEAK_LIMIT, 32'd0);
        cfg_write(lmd_pkg::REG_FRAME_ROWS, 32'd1);
        cfg_write(lmd_pkg::REG_FRAME_COLS, 32'd0);
        push_cross(16'h8000, 16'h7fff, 1'b1);
        settle(SETTLE_LIMIT);

        // shrink the frame in mid-frame: the row position is past the new height
        cfg_write(lmd_pkg::REG_THRESHOLD,  32'd0);
        cfg_write(lmd_pkg::REG_FRAME_ROWS, 32'd8);
        cfg_write(lmd_pkg::REG_FRAME_COLS, 32'd8);
        for (k = 0; k < 31; k++) push_px(gen_px(PX_FULL), k == 0);
        settle(SETTLE_LIMIT);
        cfg_write(lmd_pkg::REG_FRAME_ROWS, 32'd5);
        cfg_write(lmd_pkg::REG_FRAME_COLS, 32'd6);
        for (k = 0; k < 20; k++) push_px(gen_px(PX_FULL), 1'b0);
        settle(SETTLE_LIMIT);

        // random phases, each with new settings
        phase    = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            pick = int'($urandom_range(0, 9));
            if (pick == 0) thr_val = 16'h8000;
            else if (pick == 1) thr_val = 16'h7fff;
            else if (pick < 6) thr_val = lmd_pkg::PIX_W'($urandom_range(0, 100))
                                         - lmd_pkg::PIX_W'(50);
            else thr_val = lmd_pkg::PIX_W'($urandom);
            cfg_write(lmd_pkg::REG_THRESHOLD,
                      with_junk(lmd_pkg::APB_W'(thr_val), lmd_pkg::PIX_W));
            cfg_write(lmd_pkg::REG_FRAME_ROWS,
                      with_junk(lmd_pkg::APB_W'(pick_span()), lmd_pkg::SIZE_W));
            cfg_write(lmd_pkg::REG_FRAME_COLS,
                      with_junk(lmd_pkg::APB_W'(pick_span()), lmd_pkg::SIZE_W));

            pick = int'($urandom_range(0, 9));
            if (pick == 0) lim_val = '0;
            else if (pick == 1) lim_val = lmd_pkg::CNT_W'(1);
            else if (pick == 2) lim_val = lmd_pkg::CNT_W'(16777216);
            else if (pick < 7) lim_val = lmd_pkg::CNT_W'($urandom_range(1, 6));
            else lim_val = lmd_pkg::CNT_W'($urandom_range(7, 16777216));
            cfg_write(lmd_pkg::REG_PEAK_LIMIT,
                      with_junk(lmd_pkg::APB_W'(lim_val), lmd_pkg::CNT_W));

            pick = int'($urandom_range(0, 9));
            if (pick < 5) mode = PX_NEAR;
            else if (pick < 8) mode = PX_FULL;
            else mode = PX_EXTREME;

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // receiver stalls while pixels keep coming
            if (phase % 4 == 0) rx_hold = int'($urandom_range(150, 300));
            pause = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 60)) : -1;
            push_frames(int'($urandom_range(1, 3)), mode, pause, 1'b1,
                        RANDOM_ITEMS - n_random, pushed);
            n_random += pushed;
            settle(SETTLE_LIMIT);
            phase++;
        end

        if (peaks_due.size() != 0)
            report_mismatch($sformatf("%0d predicted peaks never came", peaks_due.size()));
        if (n_errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
